// ===== hw/rtl/jsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// jsfe_pkg
// Shared types and constants for the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

  // configuration register widths and indexes
  localparam int KEY_REG_W = 64;
  localparam int KEY_LEN_W = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LO  = 2'd0,
    CFG_KEY_HI  = 2'd1,
    CFG_KEY_LEN = 2'd2
  } jsfe_cfg_idx_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CLOSED   = 2'd1,
    KIND_UNTERM   = 2'd2,
    KIND_NOTFOUND = 2'd3
  } jsfe_kind_t;

  // character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_TAB = 8'h09;

  // one result beat
  typedef struct packed {
    jsfe_kind_t  kind;
    logic [7:0]  value_byte;
    logic        final_res;
  } jsfe_res_t;

  // up to three results caused by one body byte
  localparam int SLOTS = 3;

  typedef struct packed {
    logic [1:0]                 cnt;
    jsfe_res_t [SLOTS-1:0]      res;
  } jsfe_entry_t;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic full;
    logic nempty;
  } jsfe_qstat_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic jsfe_res_t mk_res(input jsfe_kind_t k, input logic [7:0] b);
    jsfe_res_t r;
    r.kind = k;
    r.value_byte = b;
    r.final_res = (k != KIND_BYTE);
    mk_res = r;
  endfunction

endpackage

// ===== hw/rtl/json_string_field_extractor.sv =====
// ----------------------------------------------------------------------------
// json_string_field_extractor
// Finds a quoted key in a byte stream and emits the decoded string value.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_body_byte, in_end_of_body
//  out_    | output    | out_valid/out_stall| out_kind, out_value_byte, out_final_res
//  cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
//  One body byte is taken per cycle while in_stall is low; its beats pass through
//  the queue to the output register. A byte causes up to three beats, so the
//  single output port (one beat per cycle while out_stall is low) sets the rate
//  when escapes or status beats pile up. A four-bundle queue sits between the
//  parser and the output stage; in_stall rises only when it is full. Reset
//  (rst_n low, synchronous) clears the parse state, the queue and the key registers.
// ----------------------------------------------------------------------------
module json_string_field_extractor #(
  parameter int MAX_KEY_CHARS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [jsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jsfe_pkg::KEY_REG_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_body_byte,
  input  logic                            in_end_of_body,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [7:0]                      out_value_byte,
  output logic                            out_final_res
);
  import jsfe_pkg::*;

  jsfe_entry_t entry, head;
  jsfe_qstat_t stat;
  logic        acc, push, pop;

  assign in_stall = stat.full;
  assign acc      = in_valid && !in_stall;

  jsfe_front #(
    .MAX_KEY_CHARS (MAX_KEY_CHARS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .body_byte   (in_body_byte),
    .end_of_body (in_end_of_body),
    .push        (push),
    .entry       (entry)
  );

  jsfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (entry),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  jsfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .stat           (stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value_byte (out_value_byte),
    .out_final_res  (out_final_res)
  );

endmodule

// ===== hw/rtl/jsfe_front.sv =====
// ----------------------------------------------------------------------------
// jsfe_front
// Holds the key, the byte window and the parse phase; turns each body byte
// into a bundle of zero to three result beats.
// ----------------------------------------------------------------------------
module jsfe_front #(
  parameter int MAX_KEY_CHARS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [jsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jsfe_pkg::KEY_REG_W-1:0]  cfg_wdata,
  input  logic                            acc,
  input  logic [7:0]                      body_byte,
  input  logic                            end_of_body,
  output logic                            push,
  output jsfe_pkg::jsfe_entry_t           entry
);
  import jsfe_pkg::*;

  localparam int WIN = MAX_KEY_CHARS + 2;
  localparam int SEEN_W = $clog2(WIN + 1);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WIN);
  localparam logic [KEY_LEN_W-1:0] LEN_MAX = KEY_LEN_W'(MAX_KEY_CHARS);

  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_COLON  = 5'b00010,
    PH_QUOTE  = 5'b00100,
    PH_VALUE  = 5'b01000,
    PH_DONE   = 5'b10000
  } jsfe_phase_t;

  logic [KEY_REG_W-1:0] key_lo_r, key_hi_r;
  logic [KEY_LEN_W-1:0] key_len_r;

  logic [7:0]        win_r   [WIN];
  logic [7:0]        win_nxt [WIN];
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  jsfe_phase_t       phase_r, phase_nxt;
  logic              esc_r, esc_nxt;

  logic [7:0]           key_ch [16];
  logic [KEY_LEN_W-1:0] klen;
  logic                 match;
  logic [7:0]           want;
  logic [KEY_LEN_W-1:0] kidx;
  logic [1:0]           n;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r  <= '0;
      key_hi_r  <= '0;
      key_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_LO:  key_lo_r  <= cfg_wdata;
        CFG_KEY_HI:  key_hi_r  <= cfg_wdata;
        CFG_KEY_LEN: key_len_r <= cfg_wdata[KEY_LEN_W-1:0];
        default:     ;
      endcase
    end
  end

  // key characters, low byte first
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      key_ch[i]     = key_lo_r[8*i +: 8];
      key_ch[i + 8] = key_hi_r[8*i +: 8];
    end
  end

  assign klen = (key_len_r > LEN_MAX) ? LEN_MAX : key_len_r;

  // shifted window: slot 0 is the newest byte
  always_comb begin
    win_nxt[0] = body_byte;
    for (int k = 1; k < WIN; k++) win_nxt[k] = win_r[k-1];
    seen_nxt = (seen_r == SEEN_MAX) ? seen_r : seen_r + 1'b1;
  end

  // parallel compare against the quoted key
  always_comb begin
    match = ({1'b0, seen_nxt} >= (SEEN_W+1)'(klen) + (SEEN_W+1)'(2));
    want  = CH_QUOTE;
    kidx  = '0;
    for (int k = 0; k < WIN; k++) begin
      kidx = klen - KEY_LEN_W'(k);
      if (k == 0 || KEY_LEN_W'(k) == klen + 1'b1) want = CH_QUOTE;
      else want = key_ch[kidx[3:0]];
      if (KEY_LEN_W'(k) <= klen + 1'b1 && win_nxt[k] != want) match = 1'b0;
    end
  end

  // phase machine and result bundle
  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    n         = 2'd0;
    entry     = '0;
    unique case (phase_r)
      PH_SEARCH: begin
        if (match) phase_nxt = PH_COLON;
      end
      PH_COLON: begin
        if (!is_ws(body_byte)) begin
          if (body_byte == CH_COLON) phase_nxt = PH_QUOTE;
          else begin
            entry.res[0] = mk_res(KIND_NOTFOUND, 8'h00);
            n = 2'd1;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_QUOTE: begin
        if (!is_ws(body_byte)) begin
          if (body_byte == CH_QUOTE) begin
            phase_nxt = PH_VALUE;
            esc_nxt = 1'b0;
          end else begin
            entry.res[0] = mk_res(KIND_NOTFOUND, 8'h00);
            n = 2'd1;
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_VALUE: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          n = 2'd1;
          priority if (body_byte == CH_N) entry.res[0] = mk_res(KIND_BYTE, CH_LF);
          else if (body_byte == CH_R) entry.res[0] = mk_res(KIND_BYTE, CH_CR);
          else if (body_byte == CH_T) entry.res[0] = mk_res(KIND_BYTE, CH_TAB);
          else if (body_byte == CH_BSLASH || body_byte == CH_QUOTE ||
                   body_byte == CH_SLASH) entry.res[0] = mk_res(KIND_BYTE, body_byte);
          else begin
            entry.res[0] = mk_res(KIND_BYTE, CH_BSLASH);
            entry.res[1] = mk_res(KIND_BYTE, body_byte);
            n = 2'd2;
          end
        end else if (body_byte == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (body_byte == CH_QUOTE) begin
          entry.res[0] = mk_res(KIND_CLOSED, 8'h00);
          n = 2'd1;
          phase_nxt = PH_DONE;
        end else begin
          entry.res[0] = mk_res(KIND_BYTE, body_byte);
          n = 2'd1;
        end
      end
      PH_DONE: ;
      default: phase_nxt = PH_SEARCH;
    endcase

    // end of body: status beat, then rearm
    if (end_of_body) begin
      if (phase_nxt == PH_VALUE) begin
        entry.res[n] = mk_res(KIND_UNTERM, 8'h00);
        n = n + 2'd1;
      end else if (phase_nxt != PH_DONE) begin
        entry.res[n] = mk_res(KIND_NOTFOUND, 8'h00);
        n = n + 2'd1;
      end
      phase_nxt = PH_SEARCH;
      esc_nxt = 1'b0;
    end
    entry.cnt = n;
  end

  assign push = acc && (n != 2'd0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      esc_r   <= 1'b0;
      seen_r  <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      seen_r  <= end_of_body ? '0 : seen_nxt;
    end
  end

  // window bytes
  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < WIN; k++) win_r[k] <= win_nxt[k];
    end
  end

endmodule

// ===== hw/rtl/jsfe_queue.sv =====
// ----------------------------------------------------------------------------
// jsfe_queue
// Short FIFO of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module jsfe_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  jsfe_pkg::jsfe_entry_t  wr_entry,
  input  logic                   pop,
  output jsfe_pkg::jsfe_entry_t  head,
  output jsfe_pkg::jsfe_qstat_t  stat
);
  import jsfe_pkg::*;

  jsfe_entry_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full   = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.nempty = (cnt_r != '0);
  assign do_push = push && !stat.full;
  assign do_pop  = pop && stat.nempty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule

// ===== hw/rtl/jsfe_back.sv =====
// ----------------------------------------------------------------------------
// jsfe_back
// Unpacks bundles one beat at a time into the output register.
// ----------------------------------------------------------------------------
module jsfe_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  jsfe_pkg::jsfe_entry_t  head,
  input  jsfe_pkg::jsfe_qstat_t  stat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [7:0]             out_value_byte,
  output logic                   out_final_res
);
  import jsfe_pkg::*;

  logic      out_valid_r;
  jsfe_res_t out_r;
  logic [1:0] idx_r;
  logic      load, last;

  // take a beat when the output register is free or draining
  assign load = stat.nempty && (!out_valid_r || !out_stall);
  assign last = (idx_r == head.cnt - 2'd1);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) out_r <= head.res[idx_r];
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_r.kind;
  assign out_value_byte = out_r.value_byte;
  assign out_final_res  = out_r.final_res;

endmodule

// ===== hw/rtl/jsfe_checker.sv =====
// ----------------------------------------------------------------------------
// jsfe_checker
// Port-level checks on the result channel of the extractor.
// ----------------------------------------------------------------------------
module jsfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_value_byte,
  input logic       out_final_res
);
  import jsfe_pkg::*;

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
    $stable(out_value_byte) && $stable(out_final_res))
    else $error("stalled result beat changed");

  // value bytes never close a body
  a_byte_not_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_BYTE |-> !out_final_res)
    else $error("value byte marked final");

  // status beats are final and carry no byte
  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |-> out_final_res && out_value_byte == 8'h00)
    else $error("status beat malformed");

  // reset empties the output stage
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind json_string_field_extractor jsfe_checker u_jsfe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_kind       (out_kind),
  .out_value_byte (out_value_byte),
  .out_final_res  (out_final_res)
);

// ===== sim/json_string_field_extractor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_field_extractor_test
// Streams message bodies through the extractor under several key settings
// and idling mixes. A scoreboard tracks the key search and value decoding
// per accepted byte and checks every output beat in order.
// ----------------------------------------------------------------------------
module json_string_field_extractor_test;
  import jsfe_pkg::*;

  localparam int KEY_MAX       = 16;
  localparam int WIN_BYTES     = KEY_MAX + 2;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 80;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int MAX_REPORTS   = 50;

  typedef enum logic [4:0] {
    SEEK_KEY   = 5'b00001,
    WANT_COLON = 5'b00010,
    WANT_OPEN  = 5'b00100,
    IN_VALUE   = 5'b01000,
    BODY_DONE  = 5'b10000
  } scan_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [KEY_REG_W-1:0] cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_body_byte = 8'h00;
  logic                 in_end_of_body = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_value_byte;
  logic                 out_final_res;

  json_string_field_extractor DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_body_byte   (in_body_byte),
    .in_end_of_body (in_end_of_body),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value_byte (out_value_byte),
    .out_final_res  (out_final_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // key registers as the scoreboard sees them
  logic [63:0] key_lo_q = '0;
  logic [63:0] key_hi_q = '0;
  logic [4:0]  key_len_q = '0;

  // scan state of the current body
  logic [7:0]  recent [WIN_BYTES] = '{default: 8'h00};
  int          seen = 0;
  scan_state_t scan = SEEK_KEY;
  logic        esc_open = 1'b0;

  jsfe_res_t   beats_due [$];
  body_beat_t  bytes_to_send [$];
  body_beat_t  draft [$];

  // run control
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   sender_hold = 1'b0;
  int   holds_asked = 0;
  int   holds_done = 0;
  int   hold_left = 0;
  logic in_taken = 1'b0;
  int   cycle_count = 0;

  // tallies
  int bodies_queued = 0;
  int items_queued = 0;
  int bytes_taken = 0;
  int beats_checked = 0;
  int mismatches = 0;

  // --------------------------------------------------------------------------
  // scoreboard: key search and value decoding
  // --------------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // lengths above the window capacity saturate
  function automatic int eff_key_len();
    return (key_len_q > KEY_MAX) ? KEY_MAX : int'(key_len_q);
  endfunction

  function automatic logic [7:0] key_char(input int i);
    return (i < 8) ? key_lo_q[8*i +: 8] : key_hi_q[8*(i-8) +: 8];
  endfunction

  // quoted key sits at the young end of the window
  function automatic logic key_in_window();
    int n;
    logic [7:0] want;
    n = eff_key_len() + 2;
    if (seen < n) return 1'b0;
    for (int p = 0; p < n; p++) begin
      want = (p == 0 || p == n - 1) ? CH_QUOTE : key_char(p - 1);
      if (recent[n-1-p] != want) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void queue_beat(input jsfe_kind_t k, input logic [7:0] b);
    jsfe_res_t r;
    r.kind = k;
    r.value_byte = b;
    r.final_res = (k != KIND_BYTE);
    beats_due.insert(beats_due.size(), r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    for (int i = WIN_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = b;
    if (seen < WIN_BYTES) seen++;
    case (scan)
      SEEK_KEY: begin
        if (key_in_window()) scan = WANT_COLON;
      end
      WANT_COLON: begin
        if (!is_blank(b)) begin
          if (b == CH_COLON) begin
            scan = WANT_OPEN;
          end else begin
            queue_beat(KIND_NOTFOUND, 8'h00);
            scan = BODY_DONE;
          end
        end
      end
      WANT_OPEN: begin
        if (!is_blank(b)) begin
          if (b == CH_QUOTE) begin
            scan = IN_VALUE;
            esc_open = 1'b0;
          end else begin
            queue_beat(KIND_NOTFOUND, 8'h00);
            scan = BODY_DONE;
          end
        end
      end
      IN_VALUE: begin
        if (esc_open) begin
          esc_open = 1'b0;
          case (b)
            CH_N: queue_beat(KIND_BYTE, CH_LF);
            CH_R: queue_beat(KIND_BYTE, CH_CR);
            CH_T: queue_beat(KIND_BYTE, CH_TAB);
            CH_BSLASH, CH_QUOTE, CH_SLASH: queue_beat(KIND_BYTE, b);
            default: begin
              // unknown escape passes through with its backslash
              queue_beat(KIND_BYTE, CH_BSLASH);
              queue_beat(KIND_BYTE, b);
            end
          endcase
        end else if (b == CH_BSLASH) begin
          esc_open = 1'b1;
        end else if (b == CH_QUOTE) begin
          queue_beat(KIND_CLOSED, 8'h00);
          scan = BODY_DONE;
        end else begin
          queue_beat(KIND_BYTE, b);
        end
      end
      default: ;
    endcase
    // end of body: status if none yet, then rearm
    if (last) begin
      if (scan == IN_VALUE) queue_beat(KIND_UNTERM, 8'h00);
      else if (scan != BODY_DONE) queue_beat(KIND_NOTFOUND, 8'h00);
      for (int i = 0; i < WIN_BYTES; i++) recent[i] = 8'h00;
      seen = 0;
      scan = SEEK_KEY;
      esc_open = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS)
      $display("%0t mismatch: %s got %0d, due %0d", $time, what, got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // monitor: both channels, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    jsfe_res_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      parse_byte(in_body_byte, in_end_of_body);
      bytes_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      beats_checked++;
      if (beats_due.size() == 0) begin
        report_mismatch("result beat with nothing due, kind", out_kind, -1);
      end else begin
        want = beats_due.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", out_kind, want.kind);
        if (out_value_byte !== want.value_byte)
          report_mismatch("value_byte", out_value_byte, want.value_byte);
        if (out_final_res !== want.final_res)
          report_mismatch("final_res", out_final_res, want.final_res);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_count,
               beats_due.size());
      $display("json_string_field_extractor_test: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: body bytes change on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    body_beat_t nb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (bytes_to_send.size() != 0 && !sender_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        nb = bytes_to_send.pop_front();
        in_valid <= 1'b1;
        in_body_byte <= nb.data;
        in_end_of_body <= nb.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall: random, or a long hold-off when one is asked for
  always @(negedge clk) begin : receiver
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // body building
  // --------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b);
    body_beat_t nb;
    nb.data = b;
    nb.last = 1'b0;
    draft.insert(draft.size(), nb);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_noise(input int max_len);
    repeat ($urandom_range(max_len)) add_byte(8'($urandom));
  endfunction

  // space and codes 9 to 13
  function automatic void add_blanks(input int max_len);
    int r;
    repeat ($urandom_range(max_len)) begin
      r = $urandom_range(6);
      add_byte(r > 4 ? CH_SPACE : CH_TAB + 8'(r));
    end
  endfunction

  function automatic void add_key();
    add_byte(CH_QUOTE);
    for (int i = 0; i < eff_key_len(); i++) add_byte(key_char(i));
    add_byte(CH_QUOTE);
  endfunction

  // plain characters and escapes of every sort
  function automatic void add_value(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 6) begin
        do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
        add_byte(c);
      end else begin
        add_byte(CH_BSLASH);
        case ($urandom_range(6))
          0: add_byte(CH_N);
          1: add_byte(CH_R);
          2: add_byte(CH_T);
          3: add_byte(CH_BSLASH);
          4: add_byte(CH_QUOTE);
          5: add_byte(CH_SLASH);
          default: add_byte(8'($urandom));
        endcase
      end
    end
  endfunction

  // a byte that breaks the pattern where one particular byte is wanted
  function automatic logic [7:0] stray_byte(input logic [7:0] wanted);
    logic [7:0] c;
    do c = 8'($urandom); while (is_blank(c) || c == wanted);
    return c;
  endfunction

  function automatic void close_body();
    draft[draft.size()-1].last = 1'b1;
    foreach (draft[i]) bytes_to_send.insert(bytes_to_send.size(), draft[i]);
    items_queued += draft.size();
    bodies_queued++;
    draft.delete();
  endfunction

  // mostly well-formed bodies, the rest cut short or broken
  function automatic void queue_random_body();
    int shape;
    shape = $urandom_range(15);
    add_noise(3);
    if (shape == 15) begin
      add_byte(8'($urandom));
      add_noise(6);
    end else begin
      add_key();
      if (shape == 13) begin
        add_blanks(2);
        add_byte(stray_byte(CH_COLON));
        add_noise(2);
      end else if (shape < 13) begin
        add_blanks(2);
        add_byte(CH_COLON);
        if (shape == 11) begin
          add_blanks(2);
          add_byte(stray_byte(CH_QUOTE));
          add_noise(2);
        end else if (shape != 12) begin
          add_blanks(2);
          add_byte(CH_QUOTE);
          add_value($urandom_range(5));
          if (shape == 9) begin
            add_byte(CH_BSLASH);
          end else if (shape < 9) begin
            add_byte(CH_QUOTE);
            add_noise(2);
          end
        end
      end
    end
    close_body();
  endfunction

  function automatic void run_random(input int n);
    int goal;
    goal = items_queued + n;
    while (items_queued < goal) queue_random_body();
  endfunction

  function automatic logic [63:0] key_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = 8'($urandom_range(126, 33));
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // configuration and sequencing
  // --------------------------------------------------------------------------
  task automatic write_cfg(input jsfe_cfg_idx_t idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_KEY_LO: key_lo_q = data;
      CFG_KEY_HI: key_hi_q = data;
      default:    key_len_q = data[4:0];
    endcase
  endtask

  task automatic set_key(input logic [63:0] lo, input logic [63:0] hi,
                         input logic [63:0] len_word);
    write_cfg(CFG_KEY_LO, lo);
    write_cfg(CFG_KEY_HI, hi);
    write_cfg(CFG_KEY_LEN, len_word);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // all bytes sent, all beats back, then let trailing bytes drain
  task automatic settle();
    do @(negedge clk);
    while (bytes_to_send.size() != 0 || in_valid || beats_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [63:0] w;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty key: every escape, blanks, closed value
    set_key(64'h0, 64'h0, 64'h0);
    add_text("\"\" :");
    add_byte(8'h0b);
    add_text("\"\\n\\r\\t\\\\\\\"\\/\\q\"");
    close_body();
    // broken right after the key
    add_text("\"\"x");
    close_body();
    // body ends on the key's closing quote
    add_text("\"\"");
    close_body();
    // backslash as the final byte
    add_text("\"\":\"\\");
    close_body();
    settle();

    // short key, no idling
    set_key(key_word(), key_word(), 64'd3);
    run_random(10);
    settle();

    // one-character key, sender idles
    set_key(key_word(), key_word(), 64'd1);
    send_idle_pct = 66;
    run_random(10);
    settle();

    // full-length key, receiver stalls
    set_key(key_word(), key_word(), 64'd16);
    send_idle_pct = 0;
    stall_pct = 66;
    run_random(15);
    settle();

    // oversize length saturates; junk above the length field
    w = {$urandom, $urandom};
    w[4:0] = 5'($urandom_range(31, 17));
    set_key({64{1'b1}}, 64'h0, w);
    send_idle_pct = 35;
    stall_pct = 35;
    run_random(15);
    settle();

    // back-pressure: long receiver hold-off, then a sender pause
    set_key({$urandom, $urandom}, key_word(), 64'd2);
    send_idle_pct = 0;
    stall_pct = 0;
    holds_asked++;
    run_random(25);
    do @(negedge clk); while (bytes_to_send.size() > 12);
    sender_hold = 1'b1;
    do @(negedge clk); while (beats_due.size() != 0);
    sender_hold = 1'b0;
    settle();

    $display("covered %0d bodies (%0d bytes taken) across six key and idling setups",
             bodies_queued, bytes_taken);
    $display("%0d result beats checked, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0)
      $display("json_string_field_extractor_test: PASS");
    else
      $display("json_string_field_extractor_test: FAIL");
    $finish;
  end

endmodule
